>>> rtl/core/raq_pkg.sv
// Package for the per-row absmax int8 quantizer.
// Holds default widths, field constants and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package raq_pkg;

   localparam int RAQ_SAMPLE_BITS     = 16;
   localparam int RAQ_SCALE_FRAC_BITS = 8;
   localparam int RAQ_SCALE_BITS      = 17;
   localparam int RAQ_QUANT_BITS      = 8;
   localparam int RAQ_QMAX            = 127;
   localparam int RAQ_QUANT_STEPS     = 8;

   // Divider sizing for the default parameters.
   localparam int RAQ_SCALE_STEPS =
      RAQ_SAMPLE_BITS + RAQ_SCALE_FRAC_BITS - 6;
   localparam int RAQ_REM_BITS =
      (RAQ_SAMPLE_BITS + 7 > RAQ_SAMPLE_BITS + RAQ_SCALE_FRAC_BITS + 1) ?
      RAQ_SAMPLE_BITS + 7 : RAQ_SAMPLE_BITS + RAQ_SCALE_FRAC_BITS + 1;
   localparam int RAQ_QUO_BITS =
      (RAQ_SCALE_STEPS > RAQ_QUANT_STEPS) ? RAQ_SCALE_STEPS : RAQ_QUANT_STEPS;
   localparam int RAQ_CNT_BITS = $clog2(RAQ_QUO_BITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESPOND
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/raq_req_if.sv
// Request channel of the quantizer: valid/ready plus one input item.
// Depends on raq_pkg for the default sample width.
`timescale 1ns / 1ps
`default_nettype none

interface raq_req_if #(
   parameter int SAMPLE_BITS = raq_pkg::RAQ_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          row_end;

   modport source (output valid, action, sample, row_end, input ready);
   modport sink   (input valid, action, sample, row_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/raq_rsp_if.sv
// Response channel of the quantizer: valid/ready plus one result item.
// Depends on raq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface raq_rsp_if ();
   logic                                   valid;
   logic                                   ready;
   logic                                   is_scale;
   logic [raq_pkg::RAQ_SCALE_BITS-1:0]     row_scale;
   logic signed [raq_pkg::RAQ_QUANT_BITS-1:0] quantized;

   modport source (output valid, is_scale, row_scale, quantized, input ready);
   modport sink   (input valid, is_scale, row_scale, quantized, output ready);
endinterface

`default_nettype wire

>>> rtl/core/row_absmax_int8_quantizer.sv
// Top level of the per-row absmax int8 quantizer: peak tracking, sequencer
// and response register around the shared divider.
// Depends on raq_pkg, raq_req_if, raq_rsp_if and raq_div.
`timescale 1ns / 1ps
`default_nettype none

// Each row is streamed twice: measure requests (action 0) track the largest
// magnitude; the one with row_end set latches the peak, clears the tracker
// and returns the scale peak*2^SCALE_FRAC_BITS/127 (1.0 for an all-zero
// row). Quantize requests (action 1) each return round(sample*127/peak),
// halves away from zero, saturated to +-127, or 0 while the peak is zero.
// A measure request without row_end returns nothing and the block is
// ready again in the next cycle. Every other request is handled alone:
// it is accepted, runs through the restoring divider (a quantize request
// or a scale request), has its quotient captured into the response
// register and is answered; the response is held until taken. Requests
// that answer zero or 1.0 skip the divider.
module row_absmax_int8_quantizer #(
   parameter int SAMPLE_BITS     = raq_pkg::RAQ_SAMPLE_BITS,
   parameter int SCALE_FRAC_BITS = raq_pkg::RAQ_SCALE_FRAC_BITS
) (
   input wire logic clock,
   input wire logic reset,
   raq_req_if.sink   req_ch,
   raq_rsp_if.source rsp_ch
);

   localparam int SCALE_BITS  = raq_pkg::RAQ_SCALE_BITS;
   localparam int QUANT_BITS  = raq_pkg::RAQ_QUANT_BITS;
   localparam int QUANT_STEPS = raq_pkg::RAQ_QUANT_STEPS;
   localparam int SCALE_STEPS = SAMPLE_BITS + SCALE_FRAC_BITS - 6;
   localparam int REM_BITS =
      (SAMPLE_BITS + 7 > SAMPLE_BITS + SCALE_FRAC_BITS + 1) ?
      SAMPLE_BITS + 7 : SAMPLE_BITS + SCALE_FRAC_BITS + 1;
   localparam int QUO_BITS =
      (SCALE_STEPS > QUANT_STEPS) ? SCALE_STEPS : QUANT_STEPS;
   localparam int CNT_BITS = $clog2(QUO_BITS + 1);

   raq_pkg::state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] running_peak_ff, running_peak_in;
   logic [SAMPLE_BITS-1:0] latched_peak_ff, latched_peak_in;
   logic                   neg_ff, neg_in;
   logic                   op_scale_ff, op_scale_in;
   logic                   is_scale_ff, is_scale_in;
   logic [SCALE_BITS-1:0]  row_scale_ff, row_scale_in;
   logic [QUANT_BITS-1:0]  quantized_ff, quantized_in;

   logic                   accept;
   logic [SAMPLE_BITS-1:0] sample_u;
   logic                   sample_neg;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] new_peak;

   logic                   div_start;
   logic [REM_BITS-1:0]    div_numer;
   logic [REM_BITS:0]      div_denom;
   logic [CNT_BITS-1:0]    div_steps;
   logic                   div_done;
   logic [QUO_BITS-1:0]    div_quot;

   logic [REM_BITS-1:0]    scale_numer;
   logic [REM_BITS-1:0]    quant_numer;
   logic [QUO_BITS+SCALE_BITS-1:0] quot_ext;
   logic [QUANT_BITS-2:0]  q_mag;
   logic [QUANT_BITS-1:0]  q_signed;

   assign accept     = req_ch.valid && req_ch.ready;
   assign sample_u   = req_ch.sample;
   assign sample_neg = sample_u[SAMPLE_BITS-1];
   // Most negative sample maps to 2^(SAMPLE_BITS-1), which still fits.
   assign mag        = sample_neg ? (~sample_u + SAMPLE_BITS'(1)) : sample_u;
   assign new_peak   = (mag > running_peak_ff) ? mag : running_peak_ff;

   // Scale: (2*peak*2^F + 127) / 254; quantize: (254*mag + peak) / (2*peak).
   assign scale_numer = REM_BITS'({new_peak, {(SCALE_FRAC_BITS + 1){1'b0}}})
                        + REM_BITS'(raq_pkg::RAQ_QMAX);
   assign quant_numer = (REM_BITS'(mag) << 8) - (REM_BITS'(mag) << 1)
                        + REM_BITS'(latched_peak_ff);

   // Saturate whenever the quotient reaches 128.
   assign quot_ext = {{SCALE_BITS{1'b0}}, div_quot};
   assign q_mag    = div_quot[QUANT_BITS-1] ? (QUANT_BITS-1)'(raq_pkg::RAQ_QMAX)
                                            : div_quot[QUANT_BITS-2:0];
   assign q_signed = neg_ff ? (~{1'b0, q_mag} + QUANT_BITS'(1)) : {1'b0, q_mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= raq_pkg::ST_IDLE;
         running_peak_ff <= '0;
         latched_peak_ff <= '0;
      end else begin
         state_ff        <= state_in;
         running_peak_ff <= running_peak_in;
         latched_peak_ff <= latched_peak_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      op_scale_ff  <= op_scale_in;
      is_scale_ff  <= is_scale_in;
      row_scale_ff <= row_scale_in;
      quantized_ff <= quantized_in;
   end

   always_comb begin
      state_in        = state_ff;
      running_peak_in = running_peak_ff;
      latched_peak_in = latched_peak_ff;
      neg_in          = neg_ff;
      op_scale_in     = op_scale_ff;
      is_scale_in     = is_scale_ff;
      row_scale_in    = row_scale_ff;
      quantized_in    = quantized_ff;
      div_start       = 1'b0;
      div_numer       = quant_numer;
      div_denom       = (REM_BITS + 1)'(latched_peak_ff) << 8;
      div_steps       = CNT_BITS'(QUANT_STEPS);
      req_ch.ready    = 1'b0;
      rsp_ch.valid    = 1'b0;

      unique case (state_ff)
         raq_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               neg_in = sample_neg;
               if (!req_ch.action) begin
                  running_peak_in = new_peak;
                  if (req_ch.row_end) begin
                     latched_peak_in = new_peak;
                     running_peak_in = '0;
                     op_scale_in     = 1'b1;
                     if (new_peak == '0) begin
                        is_scale_in  = 1'b1;
                        row_scale_in = SCALE_BITS'(1) << SCALE_FRAC_BITS;
                        quantized_in = '0;
                        state_in     = raq_pkg::ST_RESPOND;
                     end else begin
                        div_start = 1'b1;
                        div_numer = scale_numer;
                        div_denom = (REM_BITS + 1)'(2 * raq_pkg::RAQ_QMAX)
                                    << (SCALE_STEPS - 1);
                        div_steps = CNT_BITS'(SCALE_STEPS);
                        state_in  = raq_pkg::ST_DIVIDE;
                     end
                  end
               end else begin
                  op_scale_in = 1'b0;
                  if (latched_peak_ff == '0) begin
                     is_scale_in  = 1'b0;
                     row_scale_in = '0;
                     quantized_in = '0;
                     state_in     = raq_pkg::ST_RESPOND;
                  end else begin
                     div_start = 1'b1;
                     state_in  = raq_pkg::ST_DIVIDE;
                  end
               end
            end
         end
         raq_pkg::ST_DIVIDE: begin
            if (div_done) begin
               is_scale_in = op_scale_ff;
               if (op_scale_ff) begin
                  row_scale_in = quot_ext[SCALE_BITS-1:0];
                  quantized_in = '0;
               end else begin
                  row_scale_in = '0;
                  quantized_in = q_signed;
               end
               state_in = raq_pkg::ST_RESPOND;
            end
         end
         raq_pkg::ST_RESPOND: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               state_in = raq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = raq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.is_scale  = is_scale_ff;
   assign rsp_ch.row_scale = row_scale_ff;
   assign rsp_ch.quantized = quantized_ff;

   raq_div #(
      .REM_BITS (REM_BITS),
      .QUO_BITS (QUO_BITS),
      .CNT_BITS (CNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom_sh (div_denom),
      .steps    (div_steps),
      .done     (div_done),
      .quot     (div_quot)
   );

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == raq_pkg::ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_peak_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_ch.action && req_ch.row_end) |=> running_peak_ff == '0)
      else $error("running peak not cleared at row end");

   a_quant_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.is_scale) |->
         (rsp_ch.quantized != -8'sd128 && rsp_ch.row_scale == '0))
      else $error("quantized response out of range");

   a_scale_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.is_scale) |-> rsp_ch.quantized == '0)
      else $error("scale response carries a quantized value");

endmodule

`default_nettype wire

>>> rtl/core/raq_div.sv
// Shared restoring divider: one quotient bit per cycle against a
// pre-shifted divisor. Depends on raq_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module raq_div #(
   parameter int REM_BITS = raq_pkg::RAQ_REM_BITS,
   parameter int QUO_BITS = raq_pkg::RAQ_QUO_BITS,
   parameter int CNT_BITS = raq_pkg::RAQ_CNT_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [REM_BITS-1:0] numer,
   input  wire logic [REM_BITS:0]   denom_sh,
   input  wire logic [CNT_BITS-1:0] steps,
   output logic                     done,
   output logic [QUO_BITS-1:0]      quot
);

   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [REM_BITS:0]   dsh_ff, dsh_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                fits;
   logic [REM_BITS:0]   diff;

   assign fits = {1'b0, rem_ff} >= dsh_ff;
   assign diff = {1'b0, rem_ff} - dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         dsh_in  = denom_sh;
         quo_in  = '0;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff[REM_BITS-1:0];
         end
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

`default_nettype wire

>>> dv/row_absmax_int8_quantizer_tb.sv
// Self-checking testbench for the per-row absmax int8 quantizer.
// Drives requests and checks responses against a peak/scale predictor kept here.
// Depends on raq_pkg, raq_req_if, raq_rsp_if and the row_absmax_int8_quantizer RTL.
`timescale 1ns / 1ps

module row_absmax_int8_quantizer_tb;

   localparam int SB           = raq_pkg::RAQ_SAMPLE_BITS;
   localparam int FB           = raq_pkg::RAQ_SCALE_FRAC_BITS;
   localparam int SCALE_BITS   = raq_pkg::RAQ_SCALE_BITS;
   localparam int QUANT_BITS   = raq_pkg::RAQ_QUANT_BITS;
   localparam int QMAX         = raq_pkg::RAQ_QMAX;
   localparam bit ACT_MEASURE  = 1'b0;
   localparam bit ACT_QUANTIZE = 1'b1;
   localparam int FULL_SPAN    = 1 << (SB - 1);
   localparam int HOLD_CYCLES  = 500;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_ROW      = 24;

   typedef struct packed {
      logic                         is_scale;
      logic [SCALE_BITS-1:0]        row_scale;
      logic signed [QUANT_BITS-1:0] quantized;
   } quant_result_type;

   logic clock;
   logic reset;

   raq_req_if #(.SAMPLE_BITS(SB)) req_ch ();
   raq_rsp_if rsp_ch ();

   row_absmax_int8_quantizer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state
   logic [SB:0] peak_tracker;
   logic [SB:0] row_peak;

   quant_result_type expected_q[$];
   int unsigned   error_count;
   int unsigned   items_sent;
   int unsigned   send_idle_pct;
   int unsigned   recv_stall_pct;
   int unsigned   hold_req_count;
   int unsigned   hold_seen;
   int unsigned   hold_left;
   int unsigned   quiet_cycles;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Peak tracking, scale and rounding exactly as the block should compute them.
   function automatic bit predict_result(input bit act, input logic [SB-1:0] smp,
                                         input bit last, output quant_result_type res);
      bit                neg;
      logic [SB:0]       mag;
      longint unsigned   num;
      longint unsigned   qv;
      logic [7:0]        qbits;
      neg = smp[SB-1];
      mag = neg ? ((SB+1)'(1) << SB) - {1'b0, smp} : {1'b0, smp};
      res = '0;
      if (act == ACT_MEASURE) begin
         if (mag > peak_tracker) peak_tracker = mag;
         if (!last) return 1'b0;
         row_peak     = peak_tracker;
         peak_tracker = '0;
         res.is_scale = 1'b1;
         if (row_peak == 0) begin
            res.row_scale = SCALE_BITS'(1 << FB);
         end else begin
            num = 2 * (longint'(row_peak) << FB) + QMAX;
            res.row_scale = SCALE_BITS'(num / (2 * QMAX));
         end
         return 1'b1;
      end
      qv = 0;
      if (row_peak != 0) begin
         qv = (2 * longint'(mag) * QMAX + row_peak) / (2 * longint'(row_peak));
         if (qv > QMAX) qv = QMAX;
      end
      qbits = 8'(qv);
      res.quantized = neg ? -qbits : qbits;
      return 1'b1;
   endfunction

   function automatic logic [SB-1:0] random_sample(input int span);
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0: return '0;
         1: return SB'(span);
         2: return SB'(-span);
         default: return SB'(int'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   // Offer one request, idling first at the current rate, and record its result.
   task automatic send_request(input bit act, input logic [SB-1:0] smp, input bit last);
      quant_result_type res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid   <= 1'b0;
         req_ch.action  <= 1'($urandom);
         req_ch.sample  <= SB'($urandom);
         req_ch.row_end <= 1'($urandom);
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.sample  <= smp;
      req_ch.row_end <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (predict_result(act, smp, last, res)) expected_q.push_back(res);
      items_sent++;
   endtask

   task automatic test_directed_edges();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // quantize before any measure pass answers zero
      send_request(ACT_QUANTIZE, SB'(1000), 1'b0);
      send_request(ACT_QUANTIZE, SB'(-FULL_SPAN), 1'b1);
      // zero row: scale 1.0, quantized values zero
      send_request(ACT_MEASURE, '0, 1'b0);
      send_request(ACT_MEASURE, '0, 1'b1);
      send_request(ACT_QUANTIZE, '0, 1'b0);
      send_request(ACT_QUANTIZE, SB'(FULL_SPAN - 1), 1'b1);
      // most negative sample sets the largest peak
      send_request(ACT_MEASURE, SB'(FULL_SPAN - 1), 1'b0);
      send_request(ACT_MEASURE, SB'(-FULL_SPAN), 1'b0);
      send_request(ACT_MEASURE, SB'(5), 1'b1);
      send_request(ACT_QUANTIZE, SB'(-FULL_SPAN), 1'b0);
      send_request(ACT_QUANTIZE, SB'(FULL_SPAN - 1), 1'b0);
      send_request(ACT_QUANTIZE, SB'(129), 1'b0);
      send_request(ACT_QUANTIZE, SB'(-129), 1'b1);
      // peak of one: everything nonzero saturates
      send_request(ACT_MEASURE, SB'(-1), 1'b1);
      send_request(ACT_QUANTIZE, SB'(1), 1'b0);
      send_request(ACT_QUANTIZE, SB'(-1), 1'b0);
      send_request(ACT_QUANTIZE, SB'(FULL_SPAN - 1), 1'b0);
      send_request(ACT_QUANTIZE, SB'(-FULL_SPAN), 1'b1);
      // single-item row at the top positive value, rounding near halves
      send_request(ACT_MEASURE, SB'(FULL_SPAN - 1), 1'b1);
      send_request(ACT_QUANTIZE, SB'(129), 1'b0);
      send_request(ACT_QUANTIZE, SB'(-387), 1'b0);
      send_request(ACT_QUANTIZE, SB'(FULL_SPAN - 1), 1'b1);
      // small peak, mid-range values
      send_request(ACT_MEASURE, SB'(3), 1'b0);
      send_request(ACT_MEASURE, SB'(-7), 1'b1);
      send_request(ACT_QUANTIZE, SB'(-3), 1'b1);
   endtask

   task automatic test_random_rows(input int unsigned n_items, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
      int unsigned     goal;
      int              span;
      int              len;
      int              qlen;
      int              pick;
      bit              last;
      logic [SB-1:0]   smp;
      logic [SB-1:0]   row_samples [MAX_ROW];
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      goal = items_sent + n_items;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // noise request
            send_request(1'($urandom), SB'($urandom), 1'($urandom));
         end else begin
            case ($urandom_range(4))
               0: span = 1;
               1: span = 7;
               2: span = 255;
               3: span = FULL_SPAN - 1;
               default: span = FULL_SPAN;
            endcase
            len = ($urandom_range(9) == 0) ? $urandom_range(1, MAX_ROW) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               row_samples[i] = random_sample(span);
               // a few measure passes end without row_end and run into the next row
               last = (i == len - 1) && (pick >= 15);
               send_request(ACT_MEASURE, row_samples[i], last);
            end
            if (pick >= 20) begin
               qlen = ($urandom_range(7) == 0) ? $urandom_range(1, 8) : len;
               for (int i = 0; i < qlen; i++) begin
                  if (i < len && $urandom_range(9) != 0) smp = row_samples[i];
                  else smp = random_sample(FULL_SPAN);
                  last = (i == qlen - 1) ? ($urandom_range(7) != 0)
                                         : ($urandom_range(15) == 0);
                  send_request(ACT_QUANTIZE, smp, last);
               end
            end
         end
      end
   endtask

   // Block the response side for a long stretch while requests keep coming.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req_count++;
      for (int r = 0; r < 3; r++) begin
         send_request(ACT_MEASURE, random_sample(FULL_SPAN), 1'b0);
         send_request(ACT_MEASURE, random_sample(FULL_SPAN), 1'b1);
         for (int i = 0; i < 4; i++)
            send_request(ACT_QUANTIZE, random_sample(FULL_SPAN), i == 3);
      end
   endtask

   // response side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_req_count != hold_seen) begin
         hold_seen = hold_req_count;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      quant_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response is_scale=%0d row_scale=%0d quantized=%0d",
                     $time, rsp_ch.is_scale, rsp_ch.row_scale, rsp_ch.quantized);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_ch.is_scale !== want.is_scale) begin
               $display("%0t: is_scale expected %0d actual %0d",
                        $time, want.is_scale, rsp_ch.is_scale);
               error_count++;
            end
            if (rsp_ch.row_scale !== want.row_scale) begin
               $display("%0t: row_scale expected %0d actual %0d",
                        $time, want.row_scale, rsp_ch.row_scale);
               error_count++;
            end
            if (rsp_ch.quantized !== want.quantized) begin
               $display("%0t: quantized expected %0d actual %0d",
                        $time, want.quantized, rsp_ch.quantized);
               error_count++;
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.action  = ACT_MEASURE;
      req_ch.sample  = '0;
      req_ch.row_end = 1'b0;
      peak_tracker   = '0;
      row_peak       = '0;
      items_sent     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_req_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_random_rows(320, 0, 0);
      test_random_rows(320, 72, 0);
      test_backpressure();
      test_random_rows(320, 0, 72);
      test_random_rows(320, 37, 37);

      @(negedge clock);
      req_ch.valid   <= 1'b0;
      recv_stall_pct = 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
